// ----- rtl/core/tbc_pkg.sv -----
package tbc_pkg;

	localparam int WEIGHT_BITS = 32;
	localparam int NUM_REGS    = 6;
	localparam int REG_IDX_BITS = 3;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_AX = 3'd0,
		REG_AY = 3'd1,
		REG_BX = 3'd2,
		REG_BY = 3'd3,
		REG_CX = 3'd4,
		REG_CY = 3'd5
	} reg_idx_t;

endpackage

// ----- rtl/core/tbc_if.sv -----
interface tbc_pix_if #(parameter int COORD_BITS = 12) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	modport source (output valid, pixel_x, pixel_y, input ready);
	modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface tbc_wgt_if ();
	logic               valid;
	logic               ready;
	logic signed [31:0] weight_alpha;
	logic signed [31:0] weight_beta;
	logic signed [31:0] weight_gamma;
	logic               degenerate;
	logic               inside_res;
	modport source (output valid, weight_alpha, weight_beta, weight_gamma, degenerate,
		inside_res, input ready);
	modport sink   (input valid, weight_alpha, weight_beta, weight_gamma, degenerate,
		inside_res, output ready);
endinterface

// ----- rtl/core/tbc_div_cell.sv -----
// One restoring-division step on magnitudes: one quotient bit per cell.
module tbc_div_cell #(
	parameter int NW = 48,
	parameter int DW = 25,
	parameter int QW = 48
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num_in,
	input  logic [DW-1:0] den_in,
	input  logic [DW:0]   rem_in,
	input  logic [QW-1:0] quo_in,
	output logic [NW-1:0] num_out,
	output logic [DW-1:0] den_out,
	output logic [DW:0]   rem_out,
	output logic [QW-1:0] quo_out
);
	logic [DW+1:0] trial;
	logic [DW:0]   shifted;

	always_comb begin
		shifted = {rem_in[DW-1:0], num_in[NW-1]};
		trial   = {1'b0, shifted} - {2'b00, den_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_out <= {num_in[NW-2:0], 1'b0};
			den_out <= den_in;
			rem_out <= trial[DW+1] ? shifted : trial[DW:0];
			quo_out <= {quo_in[QW-2:0], ~trial[DW+1]};
		end
	end
endmodule

// ----- rtl/core/tbc_lane.sv -----
// Signed divide lane: chain of division cells on magnitudes, with the quotient sign carried alongside.
module tbc_lane #(
	parameter int NW = 48,
	parameter int DW = 25
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [NW-1:0]        num_mag,
	input  logic [DW-1:0]        den_mag,
	input  logic                 neg,
	output logic [NW-1:0]        quo_mag,
	output logic                 neg_out
);
	logic [NW-1:0] num_c [NW+1];
	logic [DW-1:0] den_c [NW+1];
	logic [DW:0]   rem_c [NW+1];
	logic [NW-1:0] quo_c [NW+1];
	logic          neg_c [NW+1];

	assign num_c[0] = num_mag;
	assign den_c[0] = den_mag;
	assign rem_c[0] = '0;
	assign quo_c[0] = '0;
	assign neg_c[0] = neg;

	for (genvar i = 0; i < NW; i++) begin : g_cell
		tbc_div_cell #(.NW(NW), .DW(DW), .QW(NW)) u_cell (
			.clk(clk), .en(en),
			.num_in(num_c[i]), .den_in(den_c[i]), .rem_in(rem_c[i]), .quo_in(quo_c[i]),
			.num_out(num_c[i+1]), .den_out(den_c[i+1]), .rem_out(rem_c[i+1]),
			.quo_out(quo_c[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) neg_c[i+1] <= neg_c[i];
		end
	end

	assign quo_mag = quo_c[NW];
	assign neg_out = neg_c[NW];
endmodule

// ----- rtl/core/triangle_barycentric_coordinates.sv -----
// Barycentric weights of a pixel in a configured screen triangle.
// A pixel passes the difference, product, sum and magnitude stages, the divide chains, sign and clamp, then output.
// Throughput: one pixel per cycle while the output is not stalled; each quotient bit is one cell of a divide chain.
// The whole pipe advances only when the output stage is free or being drained.
// Reset (arst_n low): vertex registers cleared to zero, all stage valids dropped.
module triangle_barycentric_coordinates #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tbc_pkg::REG_IDX_BITS-1:0]    cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	tbc_pix_if.sink                             pix,
	tbc_wgt_if.source                           wgt
);
	import tbc_pkg::*;

	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * DIFF_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;
	localparam int DW        = SUM_BITS - 1;        // magnitude of determinant
	localparam int NW        = SUM_BITS + FRAC_BITS; // magnitude of scaled numerator
	localparam int DEPTH     = NW + 5;

	localparam logic signed [NW+1:0] W_MAX = (NW+2)'(64'sd2147483647);
	localparam logic signed [NW+1:0] W_MIN = -(NW+2)'(64'sd2147483648);
	localparam logic signed [33:0]   ONE   = 34'sd1 <<< FRAC_BITS;

	// vertex registers
	logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0; cx_q <= '0; cy_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AX: ax_q <= cfg_data;
				REG_AY: ay_q <= cfg_data;
				REG_BX: bx_q <= cfg_data;
				REG_BY: by_q <= cfg_data;
				REG_CX: cx_q <= cfg_data;
				REG_CY: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// one enable for the whole pipe: advance unless the output holds a stalled request
	logic en;
	logic [DEPTH-1:0] vld_q;
	assign en = !wgt.valid || wgt.ready;
	assign pix.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[DEPTH-2:0], pix.valid};
	end

	// stage 1: edge differences
	logic signed [DIFF_BITS-1:0] e0_s1, e1_s1, e2_s1, e3_s1, dx_s1, dy_s1, dax_s1, day_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			e0_s1  <= DIFF_BITS'(by_q) - DIFF_BITS'(cy_q);
			e1_s1  <= DIFF_BITS'(cx_q) - DIFF_BITS'(bx_q);
			e2_s1  <= DIFF_BITS'(cy_q) - DIFF_BITS'(ay_q);
			e3_s1  <= DIFF_BITS'(ax_q) - DIFF_BITS'(cx_q);
			dx_s1  <= DIFF_BITS'(pix.pixel_x) - DIFF_BITS'(cx_q);
			dy_s1  <= DIFF_BITS'(pix.pixel_y) - DIFF_BITS'(cy_q);
			dax_s1 <= DIFF_BITS'(ax_q) - DIFF_BITS'(cx_q);
			day_s1 <= DIFF_BITS'(ay_q) - DIFF_BITS'(cy_q);
		end
	end

	// stage 2: products
	logic signed [PROD_BITS-1:0] pd0_s2, pd1_s2, pa0_s2, pa1_s2, pb0_s2, pb1_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			pd0_s2 <= e0_s1 * dax_s1;
			pd1_s2 <= e1_s1 * day_s1;
			pa0_s2 <= e0_s1 * dx_s1;
			pa1_s2 <= e1_s1 * dy_s1;
			pb0_s2 <= e2_s1 * dx_s1;
			pb1_s2 <= e3_s1 * dy_s1;
		end
	end

	// stage 3: sums
	logic signed [SUM_BITS-1:0] det_s3, na_s3, nb_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= SUM_BITS'(pd0_s2) + SUM_BITS'(pd1_s2);
			na_s3  <= SUM_BITS'(pa0_s2) + SUM_BITS'(pa1_s2);
			nb_s3  <= SUM_BITS'(pb0_s2) + SUM_BITS'(pb1_s2);
		end
	end

	// stage 4: magnitudes and quotient signs
	logic [NW-1:0] na_mag_s4, nb_mag_s4;
	logic [DW-1:0] den_s4;
	logic          na_neg_s4, nb_neg_s4, zero_s4;
	logic [SUM_BITS-1:0] dabs, naabs, nbabs;
	always_comb begin
		dabs  = det_s3[SUM_BITS-1] ? SUM_BITS'(-det_s3) : SUM_BITS'(det_s3);
		naabs = na_s3[SUM_BITS-1]  ? SUM_BITS'(-na_s3)  : SUM_BITS'(na_s3);
		nbabs = nb_s3[SUM_BITS-1]  ? SUM_BITS'(-nb_s3)  : SUM_BITS'(nb_s3);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			den_s4    <= dabs[DW-1:0];
			na_mag_s4 <= {naabs, {FRAC_BITS{1'b0}}};
			nb_mag_s4 <= {nbabs, {FRAC_BITS{1'b0}}};
			na_neg_s4 <= na_s3[SUM_BITS-1] ^ det_s3[SUM_BITS-1];
			nb_neg_s4 <= nb_s3[SUM_BITS-1] ^ det_s3[SUM_BITS-1];
			zero_s4   <= (det_s3 == '0);
		end
	end

	// divide chains, one quotient bit per cell
	logic [NW-1:0] qa_mag, qb_mag;
	logic          qa_neg, qb_neg;
	tbc_lane #(.NW(NW), .DW(DW)) u_lane_a (
		.clk(clk), .en(en), .num_mag(na_mag_s4), .den_mag(den_s4), .neg(na_neg_s4),
		.quo_mag(qa_mag), .neg_out(qa_neg)
	);
	tbc_lane #(.NW(NW), .DW(DW)) u_lane_b (
		.clk(clk), .en(en), .num_mag(nb_mag_s4), .den_mag(den_s4), .neg(nb_neg_s4),
		.quo_mag(qb_mag), .neg_out(qb_neg)
	);

	// carry the degenerate flag alongside the chain
	logic zero_line_q [NW+1];
	assign zero_line_q[0] = zero_s4;
	for (genvar i = 0; i < NW; i++) begin : g_zero
		always_ff @(posedge clk) begin
			if (en) zero_line_q[i+1] <= zero_line_q[i];
		end
	end

	// stage: sign and clamp
	logic signed [NW+1:0] qa_sgn, qb_sgn;
	logic signed [31:0]   al_s5, be_s5;
	logic                 zero_s5;
	always_comb begin
		qa_sgn = qa_neg ? -$signed({2'b00, qa_mag}) : $signed({2'b00, qa_mag});
		qb_sgn = qb_neg ? -$signed({2'b00, qb_mag}) : $signed({2'b00, qb_mag});
	end
	always_ff @(posedge clk) begin
		if (en) begin
			al_s5 <= (qa_sgn > W_MAX) ? 32'sh7fffffff :
				(qa_sgn < W_MIN) ? 32'sh80000000 : qa_sgn[31:0];
			be_s5 <= (qb_sgn > W_MAX) ? 32'sh7fffffff :
				(qb_sgn < W_MIN) ? 32'sh80000000 : qb_sgn[31:0];
			zero_s5 <= zero_line_q[NW];
		end
	end

	// output register: gamma, inside test, degenerate override
	logic signed [33:0] ga_w;
	logic signed [31:0] ga_c;
	logic               inside_w;
	always_comb begin
		ga_w = ONE - 34'(al_s5) - 34'(be_s5);
		ga_c = (ga_w > 34'sh7fffffff) ? 32'sh7fffffff :
			(ga_w < -34'sh80000000) ? 32'sh80000000 : ga_w[31:0];
		inside_w = (34'(al_s5) > 0) && (34'(al_s5) < ONE) && (34'(be_s5) > 0) &&
			(34'(be_s5) < ONE) && (34'(ga_c) > 0) && (34'(ga_c) < ONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wgt.valid <= 1'b0;
		else if (en) wgt.valid <= vld_q[DEPTH-1];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			wgt.weight_alpha <= zero_s5 ? '0 : al_s5;
			wgt.weight_beta  <= zero_s5 ? '0 : be_s5;
			wgt.weight_gamma <= zero_s5 ? '0 : ga_c;
			wgt.degenerate   <= zero_s5;
			wgt.inside_res   <= zero_s5 ? 1'b0 : inside_w;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wgt.valid && !wgt.ready |=> wgt.valid && $stable(wgt.weight_alpha))
		else $error("stalled weight request changed");
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		wgt.valid && wgt.degenerate |-> wgt.weight_alpha == 0 && !wgt.inside_res)
		else $error("degenerate request carries weights");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!wgt.valid |-> pix.ready)
		else $error("pipe stalled with empty output");
endmodule

// ----- verif/tb_checker.sv -----
`timescale 1ns / 1ps

module tb_checker #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data,
	tbc_pix_if.sink               pix_mon,
	tbc_wgt_if.sink               wgt_mon,
	output int                    fail_count,
	output int                    pending
);

	typedef struct {
		logic signed [31:0] alpha;
		logic signed [31:0] beta;
		logic signed [31:0] gamma;
		logic               degen;
		logic               in_tri;
	} weights_t;

	logic signed [COORD_BITS-1:0] vert[tbc_pkg::NUM_REGS];
	weights_t                     weights_q[$];

	assign pending = weights_q.size();

	function automatic longint clamp_w(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic weights_t calc_weights(logic signed [COORD_BITS-1:0] px,
		logic signed [COORD_BITS-1:0] py);
		weights_t w;
		longint ax, ay, bx, by, cx, cy, det, na, nb, al, be, ga, one;
		ax = vert[tbc_pkg::REG_AX];
		ay = vert[tbc_pkg::REG_AY];
		bx = vert[tbc_pkg::REG_BX];
		by = vert[tbc_pkg::REG_BY];
		cx = vert[tbc_pkg::REG_CX];
		cy = vert[tbc_pkg::REG_CY];
		one = longint'(1) << FRAC_BITS;
		det = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
		w = '{0, 0, 0, 1'b1, 1'b0};
		if (det == 0) return w;
		na = (by - cy) * (longint'(px) - cx) + (cx - bx) * (longint'(py) - cy);
		nb = (cy - ay) * (longint'(px) - cx) + (ax - cx) * (longint'(py) - cy);
		al = clamp_w((na * one) / det);
		be = clamp_w((nb * one) / det);
		ga = clamp_w(one - al - be);
		w.alpha = 32'(al);
		w.beta = 32'(be);
		w.gamma = 32'(ga);
		w.degen = 1'b0;
		w.in_tri = al > 0 && al < one && be > 0 && be < one && ga > 0 && ga < one;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		weights_t e;
		if (!arst_n) begin
			foreach (vert[i]) vert[i] <= '0;
			fail_count <= 0;
		end else begin
			if (pix_mon.valid && pix_mon.ready)
				weights_q.push_back(calc_weights(pix_mon.pixel_x, pix_mon.pixel_y));
			if (wgt_mon.valid && wgt_mon.ready) begin
				if (weights_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected weight request");
					fail_count <= fail_count + 1;
				end else begin
					e = weights_q.pop_front();
					if (e.alpha !== wgt_mon.weight_alpha || e.beta !== wgt_mon.weight_beta ||
						e.gamma !== wgt_mon.weight_gamma || e.degen !== wgt_mon.degenerate ||
						e.in_tri !== wgt_mon.inside_res) begin
						if (fail_count < 10)
							$display("mismatch: exp %0d %0d %0d d%b i%b, got %0d %0d %0d d%b i%b",
								e.alpha, e.beta, e.gamma, e.degen, e.in_tri,
								wgt_mon.weight_alpha, wgt_mon.weight_beta,
								wgt_mon.weight_gamma, wgt_mon.degenerate, wgt_mon.inside_res);
						fail_count <= fail_count + 1;
					end
				end
			end
			// config after sampling pixels: pixels accepted at this edge use old vertices
			if (cfg_we && cfg_index < tbc_pkg::NUM_REGS)
				vert[cfg_index] <= cfg_data;
		end
	end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	localparam int CB = 12;
	localparam int FB = 16;
	// pipe depth as reckoned from the RTL parameters, plus margin
	localparam int DRAIN_CYCLES = 2 * CB + FB + 20;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [2:0]    cfg_index = '0;
	logic [CB-1:0] cfg_data = '0;
	int            fail_count;
	int            pending;
	bit            stim_done = 1'b0;

	tbc_pix_if #(.COORD_BITS(CB)) pix ();
	tbc_wgt_if wgt ();

	initial begin
		pix.valid = 1'b0;
		pix.pixel_x = '0;
		pix.pixel_y = '0;
		wgt.ready = 1'b0;
	end

	triangle_barycentric_coordinates #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix(pix.sink), .wgt(wgt.source)
	);

	tb_checker #(.COORD_BITS(CB), .FRAC_BITS(FB)) chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix_mon(pix.sink), .wgt_mon(wgt.sink),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// drain side: random stalls of wgt.ready before each weight request, with quiet stretches
	always @(posedge clk) begin
		int stall;
		if (arst_n) begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				wgt.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			wgt.ready <= 1'b1;
			do @(posedge clk); while (!wgt.valid);
		end
	end

	// write one vertex register; only called while the pipe is empty
	task automatic write_vertex(tbc_pkg::reg_idx_t idx, logic [CB-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_triangle(int ax, int ay, int bx, int by, int cx, int cy);
		write_vertex(tbc_pkg::REG_AX, ax[CB-1:0]);
		write_vertex(tbc_pkg::REG_AY, ay[CB-1:0]);
		write_vertex(tbc_pkg::REG_BX, bx[CB-1:0]);
		write_vertex(tbc_pkg::REG_BY, by[CB-1:0]);
		write_vertex(tbc_pkg::REG_CX, cx[CB-1:0]);
		write_vertex(tbc_pkg::REG_CY, cy[CB-1:0]);
		cfg_we <= 1'b0;
	endtask

	// hold until every expected weight request is back, then let the pipe settle
	task automatic wait_idle();
		pix.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// send one pixel request, with an optional random gap first when gap_ok is set
	task automatic send_pixel(int x, int y, bit gap_ok);
		int gap;
		gap = gap_ok ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel_x <= x[CB-1:0];
		pix.pixel_y <= y[CB-1:0];
		do @(posedge clk); while (!pix.ready);
	endtask

	function automatic int rand_coord();
		case ($urandom_range(0, 5))
			0: return -2048;
			1: return 2047;
			2: return $urandom_range(0, 63) - 32;
			default: return $urandom_range(0, 4095) - 2048;
		endcase
	endfunction

	initial begin
		int ax, ay, bx, by, cx, cy, u, v;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset vertices: all zero, so every pixel is degenerate
		send_pixel(0, 0, 0);
		send_pixel(2047, -2048, 0);
		wait_idle();

		// unit-ish triangle: inside, on edges, on vertices, outside
		load_triangle(0, 0, 64, 0, 0, 64);
		send_pixel(0, 0, 0);
		send_pixel(64, 0, 0);
		send_pixel(0, 64, 0);
		send_pixel(16, 16, 0);
		send_pixel(32, 32, 0);
		send_pixel(-5, 10, 0);
		send_pixel(2047, 2047, 0);
		send_pixel(-2048, -2048, 0);
		send_pixel(-2048, 2047, 1);
		wait_idle();

		// tiny triangle at far extremes: saturating weights
		load_triangle(-2048, -2048, -2047, -2048, -2048, -2047);
		send_pixel(2047, 2047, 0);
		send_pixel(-2048, -2048, 0);
		send_pixel(2047, -2048, 0);
		send_pixel(-2048, 2047, 1);
		wait_idle();

		// huge triangle with maximal determinant, reversed winding
		load_triangle(2047, -2048, -2048, -2048, -2048, 2047);
		send_pixel(0, 0, 0);
		send_pixel(-1, -1, 0);
		send_pixel(2047, 2047, 1);
		wait_idle();

		// collinear vertices: degenerate with a nonzero setup
		load_triangle(-100, -100, 0, 0, 100, 100);
		send_pixel(5, 7, 0);
		send_pixel(-2048, 2047, 1);
		wait_idle();

		// random phases: each a new triangle, mostly pixels near it, some anywhere
		for (int ph = 0; ph < 20; ph++) begin
			ax = rand_coord(); ay = rand_coord();
			if ($urandom_range(0, 3) == 0) begin
				// small triangle, inside hits likely
				bx = ax + $urandom_range(0, 80) - 40; by = ay + $urandom_range(0, 80) - 40;
				cx = ax + $urandom_range(0, 80) - 40; cy = ay + $urandom_range(0, 80) - 40;
			end else begin
				bx = rand_coord(); by = rand_coord(); cx = rand_coord(); cy = rand_coord();
			end
			load_triangle(ax, ay, bx, by, cx, cy);
			for (int n = 0; n < 50; n++) begin
				if ($urandom_range(0, 3) != 0) begin
					// point as a random blend of the three vertices
					u = $urandom_range(0, 256);
					v = $urandom_range(0, 256 - u);
					send_pixel((ax * u + bx * v + cx * (256 - u - v)) / 256,
						(ay * u + by * v + cy * (256 - u - v)) / 256, n % 10 != 0);
				end else
					send_pixel(rand_coord(), rand_coord(), 1);
			end
			wait_idle();
		end
		stim_done = 1'b1;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- triangle_barycentric_coordinates.f -----
rtl/core/tbc_pkg.sv
rtl/core/tbc_if.sv
rtl/core/tbc_div_cell.sv
rtl/core/tbc_lane.sv
rtl/core/triangle_barycentric_coordinates.sv
verif/tb_checker.sv
verif/tb_top.sv
